### hdl/kcc_pkg.sv
// ----------------------------------------------------------------------------
// kcc_pkg: shared types and constants of the keypad chord combiner
// Event and report records, event kinds and the fixed matrix geometry.
// ----------------------------------------------------------------------------
package kcc_pkg;

	localparam int POS_W = 6;
	localparam int COL_W = 3;

	// Columns at or above this limit never take part in a chord.
	localparam logic [COL_W-1:0] COLUMN_LIMIT = 3'd6;

	// A chord is two switches seven positions apart, the lower one below 38.
	localparam int CHORD_LOW_LIMIT = 38;
	localparam int CHORD_DISTANCE  = 7;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		KIND_PASS,
		KIND_PRESS,
		KIND_RELEASE
	} kind_t;

	typedef struct packed {
		kind_t            kind;
		logic [POS_W-1:0] position;
		logic             pressed;
	} event_t;

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic             pressed;
		logic             chord;
		logic             last;
	} report_t;

endpackage

### hdl/kcc_front.sv
// ----------------------------------------------------------------------------
// kcc_front: input stage of the keypad chord combiner
// Accepts key change transactions, sorts them into pass-through, press and
// release events and hands them to the event queue.
// ----------------------------------------------------------------------------
module kcc_front #(
	parameter int CHORD_AREA = 48
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     key_valid,
	output logic                     key_stall,
	input  logic [kcc_pkg::POS_W-1:0] key_position,
	input  logic                     is_pressed,
	output logic                     push_valid,
	output kcc_pkg::event_t          push_data,
	input  logic                     push_full
);
	import kcc_pkg::*;

	localparam int AREA_W = POS_W + 1;
	localparam logic [AREA_W-1:0] AREA_LIMIT = AREA_W'(CHORD_AREA);

	logic   valid_s1;
	event_t evt_s1;
	event_t evt_in;
	logic   accept;
	logic   is_pass;

	always_comb begin
		is_pass = ({1'b0, key_position} >= AREA_LIMIT) ||
		          (key_position[COL_W-1:0] >= COLUMN_LIMIT);
		evt_in.position = key_position;
		evt_in.pressed  = is_pressed;
		if (is_pass) begin
			evt_in.kind = KIND_PASS;
		end else if (is_pressed) begin
			evt_in.kind = KIND_PRESS;
		end else begin
			evt_in.kind = KIND_RELEASE;
		end
	end

	assign key_stall  = valid_s1 && push_full;
	assign accept     = key_valid && !key_stall;
	assign push_valid = valid_s1;
	assign push_data  = evt_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (!push_full) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			evt_s1 <= evt_in;
		end
	end

endmodule

### hdl/kcc_queue.sv
// ----------------------------------------------------------------------------
// kcc_queue: event queue of the keypad chord combiner
// Short first-in first-out buffer that lets the input stage and the mask
// engine stall independently of each other.
// ----------------------------------------------------------------------------
module kcc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	input  kcc_pkg::event_t push_data,
	output logic            push_full,
	output logic            pop_valid,
	output kcc_pkg::event_t pop_data,
	input  logic            pop_ready
);
	import kcc_pkg::*;

	event_t              mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_CW-1:0] count_q;
	logic                push;
	logic                pop;

	function automatic logic [QUEUE_AW-1:0] next_ptr(input logic [QUEUE_AW-1:0] ptr);
		next_ptr = (ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
	endfunction

	assign push_full = (count_q == QUEUE_CW'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];
	assign push      = push_valid && !push_full;
	assign pop       = pop_ready && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### hdl/kcc_back.sv
// ----------------------------------------------------------------------------
// kcc_back: mask engine of the keypad chord combiner
// Keeps the held and seen masks, decides single keys and chords when the
// last switch opens, and issues up to two reports per event.
// ----------------------------------------------------------------------------
module kcc_back #(
	parameter int CHORD_AREA = 48
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      pop_valid,
	input  kcc_pkg::event_t           pop_data,
	output logic                      pop_ready,
	output logic                      report_valid,
	input  logic                      report_stall,
	output logic [kcc_pkg::POS_W-1:0] report_position,
	output logic                      report_pressed,
	output logic                      is_chord,
	output logic                      last_of_run
);
	import kcc_pkg::*;

	logic [CHORD_AREA-1:0] held_q;
	logic [CHORD_AREA-1:0] seen_q;
	logic                  out_valid_q;
	report_t               out_q;
	logic                  pend_valid_q;
	report_t               pend_q;

	logic [CHORD_AREA-1:0] key_bit;
	logic [CHORD_AREA-1:0] held_clr;
	logic [CHORD_AREA-1:0] low_mask;
	logic [CHORD_AREA-1:0] pair_low;
	logic                  held_empty;
	logic                  single;
	logic                  chord;
	logic [POS_W-1:0]      chord_pos;
	logic                  load;
	logic                  take;
	logic                  first_valid;
	logic                  second_valid;
	report_t               first;
	report_t               second;

	assign load      = !out_valid_q || !report_stall;
	assign pop_ready = load && !pend_valid_q;
	assign take      = pop_ready && pop_valid;

	always_comb begin
		key_bit    = CHORD_AREA'(1) << pop_data.position;
		held_clr   = held_q & ~key_bit;
		held_empty = (held_clr == '0);
		single     = (seen_q != '0) && ((seen_q & (seen_q - 1'b1)) == '0);

		// A chord leaves exactly one bit x with both x and x+7 seen, and
		// nothing else in the seen mask.
		for (int i = 0; i < CHORD_AREA; i++) begin
			low_mask[i] = (i < CHORD_LOW_LIMIT);
		end
		pair_low = seen_q & (seen_q >> CHORD_DISTANCE) & low_mask;
		chord    = (pair_low != '0) && ((pair_low & (pair_low - 1'b1)) == '0) &&
		           (seen_q == (pair_low | (pair_low << CHORD_DISTANCE)));
		chord_pos = '0;
		for (int i = 0; i < CHORD_AREA; i++) begin
			if (pair_low[i]) begin
				chord_pos = chord_pos | POS_W'(i);
			end
		end
	end

	always_comb begin
		first_valid  = 1'b0;
		second_valid = 1'b0;
		first        = '{position: pop_data.position, pressed: 1'b1, chord: 1'b0,
		                 last: 1'b0};
		second       = '{position: pop_data.position, pressed: 1'b0, chord: 1'b0,
		                 last: 1'b1};
		case (pop_data.kind)
			KIND_PASS: begin
				first_valid   = 1'b1;
				first.pressed = pop_data.pressed;
				first.last    = 1'b1;
			end
			KIND_RELEASE: begin
				if (held_empty && single) begin
					first_valid  = 1'b1;
					second_valid = 1'b1;
				end else if (held_empty && chord) begin
					first_valid     = 1'b1;
					second_valid    = 1'b1;
					first.position  = chord_pos;
					first.chord     = 1'b1;
					second.position = chord_pos;
					second.chord    = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q       <= '0;
			seen_q       <= '0;
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (take) begin
				case (pop_data.kind)
					KIND_PRESS: begin
						held_q <= held_q | key_bit;
						seen_q <= seen_q | key_bit;
					end
					KIND_RELEASE: begin
						held_q <= held_clr;
						if (held_empty) begin
							seen_q <= '0;
						end
					end
					default: begin
					end
				endcase
			end
			if (load) begin
				if (pend_valid_q) begin
					out_valid_q  <= 1'b1;
					pend_valid_q <= 1'b0;
				end else if (take) begin
					out_valid_q  <= first_valid;
					pend_valid_q <= second_valid;
				end else begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_valid_q) begin
				out_q <= pend_q;
			end else if (take) begin
				out_q  <= first;
				pend_q <= second;
			end
		end
	end

	assign report_valid    = out_valid_q;
	assign report_position = out_q.position;
	assign report_pressed  = out_q.pressed;
	assign is_chord        = out_q.chord;
	assign last_of_run     = out_q.last;

endmodule

### hdl/keypad_chord_combiner.sv
// ----------------------------------------------------------------------------
// keypad_chord_combiner: key matrix event to key report converter
// Passes edge keys through and merges two-switch chords into one press and release report pair.
// ----------------------------------------------------------------------------
// Input channel key_*: one transaction per switch change, position and state.
// Output channel report_*: key reports; last_of_run marks the final report
// that one input transaction causes.
// Both channels transfer when valid is high and stall is low.
// The first report of a transaction passes the input register, the queue and
// the report register before it can be taken.
// One transaction per cycle while report_stall is low and each causes at most
// one report; one with two reports holds the engine until its second is loaded,
// as the single report register issues one report per cycle.
// A two-entry queue between input stage and engine absorbs short bursts.
// Reset clears the held and seen masks, the queue and all three valid flags.
// While report_stall is high the report holds and the queue fills; key_stall
// rises once the queue and the input register are full.
// ----------------------------------------------------------------------------
module keypad_chord_combiner #(
	parameter int CHORD_AREA = 48
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      key_valid,
	output logic                      key_stall,
	input  logic [kcc_pkg::POS_W-1:0] key_position,
	input  logic                      is_pressed,
	output logic                      report_valid,
	input  logic                      report_stall,
	output logic [kcc_pkg::POS_W-1:0] report_position,
	output logic                      report_pressed,
	output logic                      is_chord,
	output logic                      last_of_run
);
	import kcc_pkg::*;

	logic   push_valid;
	event_t push_data;
	logic   push_full;
	logic   pop_valid;
	event_t pop_data;
	logic   pop_ready;

	kcc_front #(
		.CHORD_AREA(CHORD_AREA)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.key_valid    (key_valid),
		.key_stall    (key_stall),
		.key_position (key_position),
		.is_pressed   (is_pressed),
		.push_valid   (push_valid),
		.push_data    (push_data),
		.push_full    (push_full)
	);

	kcc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_full  (push_full),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop_ready  (pop_ready)
	);

	kcc_back #(
		.CHORD_AREA(CHORD_AREA)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.pop_valid       (pop_valid),
		.pop_data        (pop_data),
		.pop_ready       (pop_ready),
		.report_valid    (report_valid),
		.report_stall    (report_stall),
		.report_position (report_position),
		.report_pressed  (report_pressed),
		.is_chord        (is_chord),
		.last_of_run     (last_of_run)
	);

endmodule
